/* hw/rtl/adsf_pkg.sv */
// ----------------------------------------------------------------------------
// adsf_pkg
// Types, register codes and fixed-point helpers shared by the
// advection-diffusion stencil step block.
// ----------------------------------------------------------------------------
package adsf_pkg;

	localparam int ADDR_W = 4;

	localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
	localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;
	localparam logic signed [63:0] PROD_MAX = 64'sd2147483647;
	localparam logic signed [63:0] PROD_MIN = -64'sd2147483648;
	localparam logic signed [63:0] ROUND_HALF = 64'sd32768;

	typedef enum logic [1:0] {
		REG_DIFFUSION_GAIN = 2'd0,
		REG_STEP_GAIN      = 2'd1,
		REG_FLUX_SLOPE     = 2'd2,
		REG_FLUX_OFFSET    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] density;
		logic signed [31:0] flux;
		logic               is_last;
	} item_t;

	typedef struct packed {
		logic signed [31:0] new_density;
		logic               row_end;
	} result_t;

	typedef struct packed {
		logic signed [31:0] diffusion_gain;
		logic signed [31:0] step_gain;
		logic signed [31:0] flux_slope;
		logic signed [31:0] flux_offset;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] rm;
		logic signed [31:0] rj;
		logic signed [31:0] rp;
		logic signed [31:0] wm;
		logic signed [31:0] wj;
		logic signed [31:0] wp;
		logic               row_end;
	} job_t;

	function automatic logic signed [35:0] ext36(input logic signed [31:0] v);
		return {{4{v[31]}}, v};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > SAT_MAX) begin
			r = 32'sh7FFFFFFF;
		end else if (v < SAT_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// round to nearest (half up), drop 16 fraction bits, saturate
	function automatic logic signed [31:0] qround(input logic signed [63:0] p);
		logic signed [63:0] s;
		logic signed [31:0] r;
		s = (p + ROUND_HALF) >>> 16;
		if (s > PROD_MAX) begin
			r = 32'sh7FFFFFFF;
		end else if (s < PROD_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

endpackage

/* hw/rtl/advection_diffusion_stencil_step.sv */
// ----------------------------------------------------------------------------
// advection_diffusion_stencil_step
// Streaming explicit advection-diffusion update over one row of grid points.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   : one grid point per transaction (density, flux, is_last).
//   result channel : one updated density per transaction, row_end on the
//                    last point of a row.
//   APB port       : four 32-bit gain registers at byte addresses 0,4,8,12;
//                    write them only while the block is idle.
// A point's result is produced once its right neighbor arrives; the point
// marked is_last yields two results (its left neighbor's and its own), or
// one if it is alone in its row. In the back end each result takes a load
// in S_IDLE and nine sequencer steps (S_MA to S_MI) around seven multiplies
// through one shared 32x32 multiplier; result_valid is registered as the
// sequencer leaves S_MI. A new job is taken only in S_IDLE, so a two-entry
// job queue lets the front accept points while the back end computes.
// Reset clears the window, the queue, the sequencer and sets the registers
// to their defaults (flux slope 1.0, others 0).
// A stalled result holds in the output register; the back end waits, the
// queue fills, and then item_ready drops.
// ----------------------------------------------------------------------------
module advection_diffusion_stencil_step (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  adsf_pkg::item_t                 item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output adsf_pkg::result_t               result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [adsf_pkg::ADDR_W-1:0]     paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import adsf_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     push_valid, push_ready, pop_valid, pop_ready;
	job_t     push_data, pop_data;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.diffusion_gain <= '0;
			cfg_q.step_gain      <= '0;
			cfg_q.flux_slope     <= 32'sd65536;
			cfg_q.flux_offset    <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_DIFFUSION_GAIN: cfg_q.diffusion_gain <= pwdata;
				REG_STEP_GAIN:      cfg_q.step_gain      <= pwdata;
				REG_FLUX_SLOPE:     cfg_q.flux_slope     <= pwdata;
				REG_FLUX_OFFSET:    cfg_q.flux_offset    <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DIFFUSION_GAIN: prdata = cfg_q.diffusion_gain;
			REG_STEP_GAIN:      prdata = cfg_q.step_gain;
			REG_FLUX_SLOPE:     prdata = cfg_q.flux_slope;
			REG_FLUX_OFFSET:    prdata = cfg_q.flux_offset;
			default:            prdata = '0;
		endcase
	end

	adsf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	adsf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	adsf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	a_push_held: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && !push_ready) |=> (push_valid && $stable(push_data)))
		else $error("waiting job dropped or changed");

	a_back_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && pop_ready) |=> !pop_ready)
		else $error("back end did not start on popped job");

	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && item.is_last && push_valid && !push_data.row_end)
		|=> !item_ready)
		else $error("second job of row end not held");

endmodule

/* hw/rtl/adsf_front.sv */
// ----------------------------------------------------------------------------
// adsf_front
// Takes grid points, keeps the neighbor window and turns each point into
// zero, one or two stencil jobs for the back end.
// ----------------------------------------------------------------------------
module adsf_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  adsf_pkg::item_t item,
	output logic           push_valid,
	input  logic           push_ready,
	output adsf_pkg::job_t push_data
);
	import adsf_pkg::*;

	logic signed [31:0] dens0_q, dens1_q, flux0_q, flux1_q;
	logic               have_q;
	logic               pend_q;
	job_t               pend_job_q;
	job_t               mid_job, end_job, lone_job;
	logic               acc;

	assign item_ready = !pend_q && push_ready;
	assign acc        = item_valid && item_ready;

	always_comb begin
		mid_job  = '{rm: dens0_q, rj: dens1_q, rp: item.density,
		             wm: flux0_q, wj: flux1_q, wp: item.flux, row_end: 1'b0};
		end_job  = '{rm: dens1_q, rj: item.density, rp: '0,
		             wm: flux1_q, wj: item.flux, wp: '0, row_end: 1'b1};
		lone_job = '{rm: '0, rj: item.density, rp: '0,
		             wm: '0, wj: item.flux, wp: '0, row_end: 1'b1};
	end

	always_comb begin
		push_valid = 1'b0;
		push_data  = mid_job;
		if (pend_q) begin
			push_valid = 1'b1;
			push_data  = pend_job_q;
		end else if (acc && have_q) begin
			push_valid = 1'b1;
			push_data  = mid_job;
		end else if (acc && item.is_last) begin
			push_valid = 1'b1;
			push_data  = lone_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q  <= 1'b0;
			pend_q  <= 1'b0;
			dens0_q <= '0;
			dens1_q <= '0;
			flux0_q <= '0;
			flux1_q <= '0;
		end else begin
			if (pend_q && push_ready) begin
				pend_q <= 1'b0;
			end
			if (acc) begin
				if (item.is_last) begin
					have_q  <= 1'b0;
					dens0_q <= '0;
					dens1_q <= '0;
					flux0_q <= '0;
					flux1_q <= '0;
					pend_q  <= have_q;
				end else begin
					have_q  <= 1'b1;
					dens0_q <= have_q ? dens1_q : '0;
					flux0_q <= have_q ? flux1_q : '0;
					dens1_q <= item.density;
					flux1_q <= item.flux;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && item.is_last) begin
			pend_job_q <= end_job;
		end
	end

endmodule

/* hw/rtl/adsf_queue.sv */
// ----------------------------------------------------------------------------
// adsf_queue
// Two-entry job queue between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module adsf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  adsf_pkg::job_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output adsf_pkg::job_t pop_data
);
	import adsf_pkg::*;

	job_t       slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* hw/rtl/adsf_back.sv */
// ----------------------------------------------------------------------------
// adsf_back
// Evaluates one stencil job with a single shared 32x32 multiplier stepped
// by a sequencer, and holds the result in an output register.
// ----------------------------------------------------------------------------
module adsf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  adsf_pkg::cfg_t   cfg,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  adsf_pkg::job_t   pop_data,
	output logic             result_valid,
	input  logic             result_ready,
	output adsf_pkg::result_t result
);
	import adsf_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_MA   = 10'b0000000010,
		S_MB   = 10'b0000000100,
		S_MC   = 10'b0000001000,
		S_MD   = 10'b0000010000,
		S_ME   = 10'b0000100000,
		S_MF   = 10'b0001000000,
		S_MG   = 10'b0010000000,
		S_MH   = 10'b0100000000,
		S_MI   = 10'b1000000000
	} back_state_t;

	back_state_t        state_q;
	job_t               job_q;
	logic signed [31:0] lap_q, dw_q, krp_q, krm_q, krj_q, dk_q, t1_q, t2_q, inner_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] mul_a, mul_b, qv;
	logic               result_valid_q;
	result_t            result_q;
	logic               out_free;

	assign pop_ready    = (state_q == S_IDLE);
	assign qv           = qround(prod_q);
	assign out_free     = !result_valid_q || result_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		unique case (state_q)
			S_MA: begin
				mul_a = cfg.flux_slope;
				mul_b = job_q.rp;
			end
			S_MB: begin
				mul_a = cfg.flux_slope;
				mul_b = job_q.rm;
			end
			S_MC: begin
				mul_a = cfg.flux_slope;
				mul_b = job_q.rj;
			end
			S_MD: begin
				mul_a = cfg.diffusion_gain;
				mul_b = lap_q;
			end
			S_ME: begin
				mul_a = krj_q;
				mul_b = dw_q;
			end
			S_MF: begin
				mul_a = job_q.wj;
				mul_b = dk_q;
			end
			default: begin
				mul_a = cfg.step_gain;
				mul_b = inner_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			if (state_q == S_MI && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop_valid) begin
						state_q <= S_MA;
					end
				end
				S_MA: state_q <= S_MB;
				S_MB: state_q <= S_MC;
				S_MC: state_q <= S_MD;
				S_MD: state_q <= S_ME;
				S_ME: state_q <= S_MF;
				S_MF: state_q <= S_MG;
				S_MG: state_q <= S_MH;
				S_MH: state_q <= S_MI;
				S_MI: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			S_IDLE: begin
				job_q <= pop_data;
				lap_q <= sat32(ext36(pop_data.rm) - (ext36(pop_data.rj) <<< 1)
				               + ext36(pop_data.rp));
				dw_q  <= sat32(ext36(pop_data.wp) - ext36(pop_data.wm));
			end
			S_MB: krp_q <= sat32(ext36(qv) + ext36(cfg.flux_offset));
			S_MC: krm_q <= sat32(ext36(qv) + ext36(cfg.flux_offset));
			S_MD: begin
				krj_q <= sat32(ext36(qv) + ext36(cfg.flux_offset));
				dk_q  <= sat32(ext36(krp_q) - ext36(krm_q));
			end
			S_ME: t1_q <= qv;
			S_MF: t2_q <= qv;
			S_MG: inner_q <= sat32(ext36(t1_q) - ext36(t2_q) - ext36(qv));
			S_MI: begin
				if (out_free) begin
					result_q.new_density <= sat32(ext36(job_q.rj) + ext36(qv));
					result_q.row_end     <= job_q.row_end;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
